// ===== src/rdns_pkg.sv =====
// Shared types, constants and suffix tables for the reverse DNS name parser.
package rdns_pkg;

   localparam int MAX_NAME_LENGTH     = 255;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int IPV4_OCTETS   = 4;
   localparam int IPV4_TAIL_LEN = 12;
   localparam int IPV4_MIN_LEN  = 20;
   localparam int IPV4_MAX_LEN  = 28;
   localparam int OCTET_MAX     = 255;
   localparam int OCTET_SAT     = 256;

   localparam int IPV6_BYTES    = 16;
   localparam int IPV6_TAIL_LEN = 8;
   localparam int IPV6_NAME_LEN = 72;

   localparam logic [7:0] CHR_DOT = 8'h2e;

   typedef enum logic [1:0] {
      STATUS_IPV4    = 2'd0,
      STATUS_IPV6    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] chr;
      logic       last;
      logic       is_digit;
      logic       is_hex;
      logic       is_dot;
      logic [3:0] nib;
   } token_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic [7:0] ipv4_tail_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = "i";
         4'd1:    c = "n";
         4'd2:    c = "-";
         4'd3:    c = "a";
         4'd4:    c = "d";
         4'd5:    c = "d";
         4'd6:    c = "r";
         4'd7:    c = ".";
         4'd8:    c = "a";
         4'd9:    c = "r";
         4'd10:   c = "p";
         4'd11:   c = "a";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] ipv6_tail_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = "i";
         3'd1:    c = "p";
         3'd2:    c = "6";
         3'd3:    c = ".";
         3'd4:    c = "a";
         3'd5:    c = "r";
         3'd6:    c = "p";
         3'd7:    c = "a";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== src/reverse_dns_name_parser.sv =====
// Top level of the reverse DNS name parser: front end, token queue and parser.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  req_name_char, req_last_char
//   rsp       out         rsp_valid / rsp_stall  rsp_status, rsp_address_high, rsp_address_low
//
// One character is taken per cycle while req_stall is low, and the parser consumes one queued
// token per cycle; once it pops the last token the result is registered and rsp_valid rises.
// Reset clears the queue, parse counters, flags and rsp_valid at once; no clearing pass.
// req_stall rises only when the QUEUE_DEPTH-entry token queue is full.
// rsp_stall holds only a last-character token in the queue; other characters keep flowing.
module reverse_dns_name_parser #(
   parameter int QUEUE_DEPTH = rdns_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_name_char,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_address_high,
   output logic [63:0] rsp_address_low
);
   import rdns_pkg::*;

   queue_status_type q_status;
   token_type        push_token;
   token_type        head_token;
   logic             push;
   logic             tok_pop;
   status_type       status_w;

   rdns_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_name_char (req_name_char),
      .req_last_char (req_last_char),
      .q_status      (q_status),
      .push          (push),
      .token         (push_token)
   );

   rdns_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (tok_pop),
      .head_token (head_token),
      .q_status   (q_status)
   );

   rdns_back u_back (
      .clock            (clock),
      .reset            (reset),
      .tok              (head_token),
      .q_status         (q_status),
      .tok_pop          (tok_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (status_w),
      .rsp_address_high (rsp_address_high),
      .rsp_address_low  (rsp_address_low)
   );

   assign rsp_status = status_w;

`ifndef SYNTHESIS
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status_w == STATUS_INVALID) |->
         (rsp_address_high == 64'h0 && rsp_address_low == 64'h0))
      else $error("invalid name carries a nonzero address");

   a_ipv4_narrow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status_w == STATUS_IPV4) |->
         (rsp_address_high == 64'h0 && rsp_address_low[63:32] == 32'h0))
      else $error("IPv4 result has bits above the low 32");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      tok_pop |-> !q_status.empty)
      else $error("parser took a token from an empty queue");

   a_full_after_push: assert property (@(posedge clock) disable iff (reset)
      (q_status.full && !tok_pop) |=> q_status.full)
      else $error("full queue drained without a pop");
`endif

endmodule

// ===== src/rdns_front.sv =====
// Front end: takes characters and classifies them into tokens for the queue.
module rdns_front (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_name_char,
   input  logic                         req_last_char,
   input  rdns_pkg::queue_status_type   q_status,
   output logic                         push,
   output rdns_pkg::token_type          token
);
   import rdns_pkg::*;

   logic is_digit;
   logic is_af;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      is_digit = req_name_char inside {[8'h30:8'h39]};
      is_af    = req_name_char inside {[8'h61:8'h66]};
      token.chr      = req_name_char;
      token.last     = req_last_char;
      token.is_digit = is_digit;
      token.is_hex   = is_digit || is_af;
      token.is_dot   = (req_name_char == CHR_DOT);
      token.nib      = is_af ? (req_name_char[3:0] + 4'd9) : req_name_char[3:0];
   end

endmodule

// ===== src/rdns_queue.sv =====
// Token queue between the front end and the parser.
module rdns_queue #(
   parameter int QUEUE_DEPTH = rdns_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  rdns_pkg::token_type          push_token,
   input  logic                         pop,
   output rdns_pkg::token_type          head_token,
   output rdns_pkg::queue_status_type   q_status
);
   import rdns_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   token_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

   assign head_token     = entry_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));

endmodule

// ===== src/rdns_back.sv =====
// Back end: runs the IPv4 and IPv6 parsers side by side and registers the result.
module rdns_back (
   input  logic                         clock,
   input  logic                         reset,
   input  rdns_pkg::token_type          tok,
   input  rdns_pkg::queue_status_type   q_status,
   output logic                         tok_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output rdns_pkg::status_type         rsp_status,
   output logic [63:0]                  rsp_address_high,
   output logic [63:0]                  rsp_address_low
);
   import rdns_pkg::*;

   localparam logic [1:0] PH_LOW  = 2'd0;
   localparam logic [1:0] PH_DOT1 = 2'd1;
   localparam logic [1:0] PH_HIGH = 2'd2;
   localparam logic [1:0] PH_DOT2 = 2'd3;

   logic [7:0]   char_count_ff, char_count_nx, char_count_in;
   logic [8:0]   octet_value_ff, octet_value_nx, octet_value_in;
   logic [2:0]   octet_count_ff, octet_count_nx, octet_count_in;
   logic [31:0]  ipv4_address_ff, ipv4_address_in;
   logic [3:0]   ipv4_suffix_pos_ff, ipv4_suffix_pos_nx, ipv4_suffix_pos_in;
   logic         ipv4_bad_ff, ipv4_bad_nx, ipv4_bad_in;
   logic [1:0]   nibble_phase_ff, nibble_phase_nx, nibble_phase_in;
   logic [3:0]   low_nibble_ff, low_nibble_in;
   logic [4:0]   byte_count_ff, byte_count_nx, byte_count_in;
   logic [127:0] ipv6_address_ff, ipv6_address_in;
   logic [3:0]   ipv6_suffix_pos_ff, ipv6_suffix_pos_nx, ipv6_suffix_pos_in;
   logic         ipv6_bad_ff, ipv6_bad_nx, ipv6_bad_in;

   logic         rsp_valid_ff, rsp_valid_in;
   status_type   rsp_status_ff, rsp_status_in;
   logic [63:0]  rsp_high_ff, rsp_high_in;
   logic [63:0]  rsp_low_ff, rsp_low_in;

   logic [11:0]  octet_product;
   logic         finish;
   logic         v4_ok;
   logic         v6_ok;

   assign tok_pop = !q_status.empty && (!tok.last || !rsp_valid_ff || !rsp_stall);
   assign finish  = tok_pop && tok.last;
   assign octet_product = ({3'b000, octet_value_ff} << 3) + ({3'b000, octet_value_ff} << 1)
                        + {8'h00, tok.nib};

   // advance both parsers on one token
   always_comb begin
      char_count_nx      = char_count_ff;
      octet_value_nx     = octet_value_ff;
      octet_count_nx     = octet_count_ff;
      ipv4_address_in    = ipv4_address_ff;
      ipv4_suffix_pos_nx = ipv4_suffix_pos_ff;
      ipv4_bad_nx        = ipv4_bad_ff;
      nibble_phase_nx    = nibble_phase_ff;
      low_nibble_in      = low_nibble_ff;
      byte_count_nx      = byte_count_ff;
      ipv6_address_in    = ipv6_address_ff;
      ipv6_suffix_pos_nx = ipv6_suffix_pos_ff;
      ipv6_bad_nx        = ipv6_bad_ff;
      if (tok_pop) begin
         if (char_count_ff != 8'hff) begin
            char_count_nx = char_count_ff + 1'b1;
         end
         if (!ipv4_bad_ff) begin
            if (octet_count_ff < 3'(IPV4_OCTETS)) begin
               if (tok.is_digit) begin
                  octet_value_nx = (octet_product > 12'(OCTET_SAT)) ? 9'(OCTET_SAT)
                                                                    : octet_product[8:0];
               end else if (tok.is_dot && octet_value_ff <= 9'(OCTET_MAX)) begin
                  ipv4_address_in[8*octet_count_ff[1:0] +: 8] = octet_value_ff[7:0];
                  octet_count_nx = octet_count_ff + 1'b1;
                  octet_value_nx = '0;
               end else begin
                  ipv4_bad_nx = 1'b1;
               end
            end else if (ipv4_suffix_pos_ff < 4'(IPV4_TAIL_LEN) &&
                         tok.chr == ipv4_tail_char(ipv4_suffix_pos_ff)) begin
               ipv4_suffix_pos_nx = ipv4_suffix_pos_ff + 1'b1;
            end else begin
               ipv4_bad_nx = 1'b1;
            end
         end
         if (!ipv6_bad_ff) begin
            if (byte_count_ff < 5'(IPV6_BYTES)) begin
               case (nibble_phase_ff)
                  PH_LOW: begin
                     if (tok.is_hex) begin
                        low_nibble_in   = tok.nib;
                        nibble_phase_nx = PH_DOT1;
                     end else begin
                        ipv6_bad_nx = 1'b1;
                     end
                  end
                  PH_HIGH: begin
                     if (tok.is_hex) begin
                        ipv6_address_in[8*byte_count_ff[3:0] +: 8] = {tok.nib, low_nibble_ff};
                        nibble_phase_nx = PH_DOT2;
                     end else begin
                        ipv6_bad_nx = 1'b1;
                     end
                  end
                  PH_DOT1: begin
                     if (tok.is_dot) begin
                        nibble_phase_nx = PH_HIGH;
                     end else begin
                        ipv6_bad_nx = 1'b1;
                     end
                  end
                  PH_DOT2: begin
                     if (tok.is_dot) begin
                        byte_count_nx   = byte_count_ff + 1'b1;
                        nibble_phase_nx = PH_LOW;
                     end else begin
                        ipv6_bad_nx = 1'b1;
                     end
                  end
                  default: ipv6_bad_nx = 1'b1;
               endcase
            end else if (ipv6_suffix_pos_ff < 4'(IPV6_TAIL_LEN) &&
                         tok.chr == ipv6_tail_char(ipv6_suffix_pos_ff[2:0])) begin
               ipv6_suffix_pos_nx = ipv6_suffix_pos_ff + 1'b1;
            end else begin
               ipv6_bad_nx = 1'b1;
            end
         end
      end
   end

   // judge the name on its last character, then clear the parse counters and flags
   always_comb begin
      v4_ok = !ipv4_bad_nx && octet_count_nx == 3'(IPV4_OCTETS) &&
              ipv4_suffix_pos_nx == 4'(IPV4_TAIL_LEN) &&
              char_count_nx >= 8'(IPV4_MIN_LEN) && char_count_nx <= 8'(IPV4_MAX_LEN) &&
              char_count_nx <= 8'(MAX_NAME_LENGTH);
      v6_ok = !ipv6_bad_nx && byte_count_nx == 5'(IPV6_BYTES) &&
              ipv6_suffix_pos_nx == 4'(IPV6_TAIL_LEN) &&
              char_count_nx == 8'(IPV6_NAME_LEN) && char_count_nx <= 8'(MAX_NAME_LENGTH);

      char_count_in      = finish ? '0 : char_count_nx;
      octet_value_in     = finish ? '0 : octet_value_nx;
      octet_count_in     = finish ? '0 : octet_count_nx;
      ipv4_suffix_pos_in = finish ? '0 : ipv4_suffix_pos_nx;
      ipv4_bad_in        = finish ? 1'b0 : ipv4_bad_nx;
      nibble_phase_in    = finish ? PH_LOW : nibble_phase_nx;
      byte_count_in      = finish ? '0 : byte_count_nx;
      ipv6_suffix_pos_in = finish ? '0 : ipv6_suffix_pos_nx;
      ipv6_bad_in        = finish ? 1'b0 : ipv6_bad_nx;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_low_in    = rsp_low_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         if (v4_ok) begin
            rsp_status_in = STATUS_IPV4;
            rsp_high_in   = '0;
            rsp_low_in    = {32'h0, ipv4_address_in};
         end else if (v6_ok) begin
            rsp_status_in = STATUS_IPV6;
            rsp_high_in   = ipv6_address_in[127:64];
            rsp_low_in    = ipv6_address_in[63:0];
         end else begin
            rsp_status_in = STATUS_INVALID;
            rsp_high_in   = '0;
            rsp_low_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff      <= '0;
         octet_value_ff     <= '0;
         octet_count_ff     <= '0;
         ipv4_suffix_pos_ff <= '0;
         ipv4_bad_ff        <= 1'b0;
         nibble_phase_ff    <= PH_LOW;
         byte_count_ff      <= '0;
         ipv6_suffix_pos_ff <= '0;
         ipv6_bad_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         char_count_ff      <= char_count_in;
         octet_value_ff     <= octet_value_in;
         octet_count_ff     <= octet_count_in;
         ipv4_suffix_pos_ff <= ipv4_suffix_pos_in;
         ipv4_bad_ff        <= ipv4_bad_in;
         nibble_phase_ff    <= nibble_phase_in;
         byte_count_ff      <= byte_count_in;
         ipv6_suffix_pos_ff <= ipv6_suffix_pos_in;
         ipv6_bad_ff        <= ipv6_bad_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ipv4_address_ff <= ipv4_address_in;
      low_nibble_ff   <= low_nibble_in;
      ipv6_address_ff <= ipv6_address_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_high_ff     <= rsp_high_in;
      rsp_low_ff      <= rsp_low_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_address_high = rsp_high_ff;
   assign rsp_address_low  = rsp_low_ff;

endmodule

// ===== sim/reverse_dns_name_parser_tb.sv =====
// Testbench for the reverse DNS name parser: directed and random query names, checked per result.
module reverse_dns_name_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rdns_pkg::*;

   typedef logic [7:0] chars_type[$];

   typedef struct {
      status_type  status;
      logic [63:0] high;
      logic [63:0] low;
   } ptr_answer_type;

   localparam string V4_SUFFIX        = "in-addr.arpa";
   localparam string V6_SUFFIX        = "ip6.arpa";
   localparam int    LONG_HOLD_CYCLES = 200;
   localparam int    RANDOM_CHARS     = 60;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_name_char;
   logic        req_last_char;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_address_high;
   logic [63:0] rsp_address_low;

   // name tracking state
   logic [7:0]  name_len;
   logic [8:0]  label_value;
   logic [2:0]  label_count;
   logic [31:0] v4_addr;
   logic [3:0]  v4_tail_pos;
   logic        v4_fail;
   logic [1:0]  nib_phase;
   logic [3:0]  low_nib;
   logic [4:0]  v6_bytes;
   logic [63:0] v6_hi;
   logic [63:0] v6_lo;
   logic [3:0]  v6_tail_pos;
   logic        v6_fail;

   ptr_answer_type pending_answers[$];
   int          error_count = 0;
   int          chars_sent  = 0;
   bit          gaps_on     = 1'b0;
   bit          pacing_on   = 1'b0;
   bit          long_hold_req = 1'b0;

   reverse_dns_name_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_name_char    (req_name_char),
      .req_last_char    (req_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_address_high (rsp_address_high),
      .rsp_address_low  (rsp_address_low)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("status: fail");
      $finish;
   end

   function automatic void clear_name_state();
      name_len    = '0;
      label_value = '0;
      label_count = '0;
      v4_addr     = '0;
      v4_tail_pos = '0;
      v4_fail     = 1'b0;
      nib_phase   = '0;
      low_nib     = '0;
      v6_bytes    = '0;
      v6_hi       = '0;
      v6_lo       = '0;
      v6_tail_pos = '0;
      v6_fail     = 1'b0;
   endfunction

   // bit 4 set: not a lowercase hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return {1'b0, 4'(c - "0")};
      end else if (c >= "a" && c <= "f") begin
         return {1'b0, 4'(c - "a" + 8'd10)};
      end
      return 5'h10;
   endfunction

   function automatic void track_char(input logic [7:0] c, input logic last);
      int unsigned v;
      logic [4:0]  h;
      logic [7:0]  b;
      logic        v4_ok;
      logic        v6_ok;
      ptr_answer_type ans;
      if (name_len != 8'd255) name_len++;

      if (!v4_fail) begin
         if (label_count < 3'(IPV4_OCTETS)) begin
            if (c >= "0" && c <= "9") begin
               v = label_value * 10 + (c - "0");
               label_value = (v > OCTET_SAT) ? 9'(OCTET_SAT) : 9'(v);
            end else if (c == CHR_DOT && label_value <= OCTET_MAX) begin
               v4_addr |= 32'(label_value[7:0]) << (8 * label_count);
               label_count++;
               label_value = '0;
            end else begin
               v4_fail = 1'b1;
            end
         end else if (v4_tail_pos < IPV4_TAIL_LEN && c == V4_SUFFIX[v4_tail_pos]) begin
            v4_tail_pos++;
         end else begin
            v4_fail = 1'b1;
         end
      end

      if (!v6_fail) begin
         if (v6_bytes < IPV6_BYTES) begin
            if (nib_phase == 2'd0 || nib_phase == 2'd2) begin
               h = hex_digit(c);
               if (h[4]) begin
                  v6_fail = 1'b1;
               end else begin
                  if (nib_phase == 2'd0) begin
                     low_nib = h[3:0];
                  end else begin
                     b = {h[3:0], low_nib};
                     if (v6_bytes < 5'd8) v6_lo |= 64'(b) << (8 * v6_bytes);
                     else v6_hi |= 64'(b) << (8 * (v6_bytes - 5'd8));
                  end
                  nib_phase++;
               end
            end else if (c != CHR_DOT) begin
               v6_fail = 1'b1;
            end else begin
               if (nib_phase == 2'd3) v6_bytes++;
               nib_phase++;
            end
         end else if (v6_tail_pos < IPV6_TAIL_LEN && c == V6_SUFFIX[v6_tail_pos]) begin
            v6_tail_pos++;
         end else begin
            v6_fail = 1'b1;
         end
      end

      if (last) begin
         v4_ok = !v4_fail && label_count == IPV4_OCTETS && v4_tail_pos == IPV4_TAIL_LEN &&
                 name_len >= IPV4_MIN_LEN && name_len <= IPV4_MAX_LEN &&
                 name_len <= MAX_NAME_LENGTH;
         v6_ok = !v6_fail && v6_bytes == IPV6_BYTES && v6_tail_pos == IPV6_TAIL_LEN &&
                 name_len == IPV6_NAME_LEN && name_len <= MAX_NAME_LENGTH;
         if (v4_ok) begin
            ans.status = STATUS_IPV4;
            ans.high   = '0;
            ans.low    = {32'd0, v4_addr};
         end else if (v6_ok) begin
            ans.status = STATUS_IPV6;
            ans.high   = v6_hi;
            ans.low    = v6_lo;
         end else begin
            ans.status = STATUS_INVALID;
            ans.high   = '0;
            ans.low    = '0;
         end
         pending_answers.push_back(ans);
         clear_name_state();
      end
   endfunction

   function automatic void note_error(input string what);
      if (error_count < 10) $display("mismatch: %s", what);
      error_count++;
   endfunction

   always @(posedge clock) begin
      ptr_answer_type exp_ans;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            note_error($sformatf("unexpected transfer: status %0d high %h low %h",
                                 rsp_status, rsp_address_high, rsp_address_low));
         end else begin
            exp_ans = pending_answers.pop_front();
            if (rsp_status !== exp_ans.status || rsp_address_high !== exp_ans.high ||
                rsp_address_low !== exp_ans.low) begin
               note_error($sformatf("status exp %0d got %0d, high exp %h got %h, low exp %h got %h",
                                    exp_ans.status, rsp_status, exp_ans.high, rsp_address_high,
                                    exp_ans.low, rsp_address_low));
            end
         end
      end
   end

   initial begin : rsp_pacing
      int run_left;
      int hold_left;
      int r;
      run_left  = 0;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!pacing_on) begin
            rsp_stall <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
         end else begin
            rsp_stall <= !rsp_stall;
            r = $urandom_range(0, 99);
            if (rsp_stall) run_left = $urandom_range(0, 10);
            else if (r < 70) run_left = $urandom_range(0, 1);
            else if (r < 95) run_left = $urandom_range(2, 7);
            else run_left = $urandom_range(20, 50);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_name_char <= c;
      req_last_char <= last;
      do @(posedge clock); while (req_stall);
      track_char(c, last);
      chars_sent++;
   endtask

   task automatic send_name(input chars_type name);
      for (int i = 0; i < name.size(); i++) send_char(name[i], i == name.size() - 1);
   endtask

   function automatic chars_type text_to_chars(input string s);
      chars_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   function automatic chars_type ipv4_name(input logic [31:0] addr, input logic [3:0] pad);
      string s;
      string label;
      s = "";
      for (int i = 0; i < 4; i++) begin
         if (pad[i]) label = $sformatf("%03d", addr[8*i +: 8]);
         else label = $sformatf("%0d", addr[8*i +: 8]);
         s = {s, label, "."};
      end
      return text_to_chars({s, V4_SUFFIX});
   endfunction

   function automatic chars_type ipv6_name(input logic [127:0] addr);
      string s;
      logic [7:0] b;
      s = "";
      for (int k = 0; k < 16; k++) begin
         b = addr[8*k +: 8];
         s = {s, $sformatf("%h.%h.", b[3:0], b[7:4])};
      end
      return text_to_chars({s, V6_SUFFIX});
   endfunction

   function automatic logic [7:0] pick_octet();
      case ($urandom_range(0, 3))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic chars_type mangle(input chars_type n);
      chars_type m;
      int p;
      m = n;
      p = $urandom_range(0, m.size() - 1);
      case ($urandom_range(0, 4))
         0: m[p] = 8'($urandom_range(0, 255));
         1: while (m.size() > p + 1) void'(m.pop_back());
         2: repeat ($urandom_range(1, 4)) m.push_back(8'($urandom_range(33, 126)));
         3: begin
            if (m[p] >= "a" && m[p] <= "z") m[p] = m[p] - 8'h20;
            else m[p] = CHR_DOT;
         end
         default: m.insert(p, 8'($urandom_range(0, 255)));
      endcase
      return m;
   endfunction

   task automatic send_random_name();
      chars_type name;
      string s;
      int k;
      k = $urandom_range(0, 9);
      if (k < 4) begin
         name = ipv4_name({pick_octet(), pick_octet(), pick_octet(), pick_octet()},
                          4'($urandom_range(0, 15)));
      end else if (k < 6) begin
         name = ipv6_name({$urandom, $urandom, $urandom, $urandom});
      end else if (k < 8) begin
         if ($urandom_range(0, 1)) name = ipv4_name($urandom, 4'($urandom_range(0, 15)));
         else name = ipv6_name({$urandom, $urandom, $urandom, $urandom});
         name = mangle(name);
      end else if (k == 8) begin
         repeat ($urandom_range(1, 30)) name.push_back(8'($urandom_range(0, 255)));
      end else begin
         s = "";
         repeat ($urandom_range(3, 5)) s = {s, $sformatf("%0d.", $urandom_range(0, 999))};
         name = text_to_chars({s, V4_SUFFIX});
      end
      send_name(name);
   endtask

   task automatic test_ipv4_names();
      send_name(ipv4_name(32'h00000000, 4'h0));
      send_name(ipv4_name(32'hffffffff, 4'hf));
      send_name(ipv4_name(32'h01020304, 4'h0));
      send_name(text_to_chars("0001.2.3.4.in-addr.arpa"));
      send_name(text_to_chars(".10.10.1.in-addr.arpa"));
      send_name(text_to_chars(".1.1.1.in-addr.arpa"));
      send_name(text_to_chars("0001.002.003.004.in-addr.arpa"));
      send_name(text_to_chars("256.1.1.1.in-addr.arpa"));
      send_name(text_to_chars("99999999.1.1.1.in-addr.arpa"));
      send_name(text_to_chars("1.2.3.4.in-addr.arpa."));
   endtask

   task automatic test_ipv6_names();
      chars_type name;
      send_name(ipv6_name('0));
      send_name(ipv6_name({128{1'b1}}));
      send_name(ipv6_name({$urandom, $urandom, $urandom, $urandom}));
      name = ipv6_name({16{8'haa}});
      name[0] = "A";
      send_name(name);
      name = ipv6_name({$urandom, $urandom, $urandom, $urandom});
      void'(name.pop_back());
      send_name(name);
      name = ipv6_name({$urandom, $urandom, $urandom, $urandom});
      name.push_back("a");
      send_name(name);
   endtask

   task automatic test_odd_characters();
      chars_type name;
      name = text_to_chars("1.2.3.4.in-addr.arpa");
      name[3] = 8'h00;
      send_name(name);
      name = '{8'hff};
      send_name(name);
      name = '{CHR_DOT};
      send_name(name);
      name = {};
      repeat (20) name.push_back("1");
      send_name(name);
      name = {};
      repeat (256) name.push_back("a");
      send_name(name);
   endtask

   task automatic test_random_names();
      int stop_at;
      stop_at = chars_sent + RANDOM_CHARS;
      while (chars_sent < stop_at) send_random_name();
   endtask

   task automatic test_no_idle();
      gaps_on   = 1'b0;
      pacing_on = 1'b0;
      repeat (2) send_random_name();
      gaps_on   = 1'b1;
      pacing_on = 1'b1;
   endtask

   task automatic test_backpressure();
      gaps_on       = 1'b0;
      long_hold_req = 1'b1;
      repeat (4) send_name(ipv4_name($urandom, 4'($urandom_range(0, 15))));
      gaps_on       = 1'b1;
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_name_char <= '0;
      req_last_char <= 1'b0;
      clear_name_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      gaps_on   = 1'b1;
      pacing_on = 1'b1;

      test_ipv4_names();
      test_ipv6_names();
      test_odd_characters();
      test_random_names();
      test_no_idle();
      test_backpressure();

      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
src/rdns_pkg.sv
src/rdns_front.sv
src/rdns_queue.sv
src/rdns_back.sv
src/reverse_dns_name_parser.sv
sim/reverse_dns_name_parser_tb.sv
